### design/b64sp_pkg.sv
// ----------------------------------------------------------------------------
// b64sp_pkg
// Types, character codes and symbol lookup for the space-padded base64
// encoder.
// ----------------------------------------------------------------------------
package b64sp_pkg;

    localparam int CHAR_W    = 7;
    localparam int MAX_CHARS = 5;
    localparam int CNT_W     = 3;

    localparam logic [CHAR_W-1:0] CH_TERM  = 7'h2d;  // '-'
    localparam logic [CHAR_W-1:0] CH_PAD   = 7'h20;  // ' '
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;  // '+'
    localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2f;  // '/'
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_D0    = 7'h30;  // '0'

    typedef logic [1:0] t_phase;

    localparam t_phase PH_EMPTY = 2'd0;
    localparam t_phase PH_ONE   = 2'd1;
    localparam t_phase PH_TWO   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic                              term;
        logic [MAX_CHARS-1:0][CHAR_W-1:0]  chars;
    } t_job;

    function automatic logic [CHAR_W-1:0] sym_of(input logic [5:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 6'd26) begin
            r = CH_UA + {1'b0, v};
        end else if (v < 6'd52) begin
            r = CH_LA + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            r = CH_D0 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            r = CH_PLUS;
        end else begin
            r = CH_SLASH;
        end
        return r;
    endfunction

endpackage

### design/b64sp_in_reg.sv
// ----------------------------------------------------------------------------
// b64sp_in_reg
// Input register: captures one byte request and holds it until the group
// stage consumes it.
// ----------------------------------------------------------------------------
module b64sp_in_reg
    import b64sp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_empty,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_empty
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_empty;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_byte;
            r_last  <= i_last;
            r_empty <= i_empty;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_empty = r_empty;

endmodule

### design/b64sp_group.sv
// ----------------------------------------------------------------------------
// b64sp_group
// Group assembler: keeps the bytes of the current 3-byte group and forms the
// characters of a completed or closed group.
// ----------------------------------------------------------------------------
module b64sp_group
    import b64sp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_empty,
    input  logic       i_buf_free,
    output logic       o_advance,
    output t_job       o_job
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;

    logic [7:0] a, b, c;
    logic [1:0] nbytes;
    t_job       job;

    always_comb begin
        a        = 8'd0;
        b        = 8'd0;
        c        = 8'd0;
        nbytes   = 2'd1;
        job      = '0;
        n_phase  = PH_EMPTY;
        n_first  = 8'd0;
        n_second = 8'd0;
        if (i_empty) begin
            job.count    = CNT_W'(1);
            job.term     = 1'b1;
            job.chars[0] = CH_TERM;
        end else if (r_phase == PH_ONE) begin
            a      = r_first;
            b      = i_byte;
            nbytes = 2'd2;
            if (i_last) begin
                job.count = CNT_W'(MAX_CHARS);
                job.term  = 1'b1;
            end else begin
                n_phase  = PH_TWO;
                n_first  = r_first;
                n_second = i_byte;
            end
        end else if (r_phase == PH_TWO) begin
            a         = r_first;
            b         = r_second;
            c         = i_byte;
            nbytes    = 2'd3;
            job.term  = i_last;
            job.count = i_last ? CNT_W'(MAX_CHARS) : CNT_W'(MAX_CHARS - 1);
        end else begin
            a = i_byte;
            if (i_last) begin
                job.count = CNT_W'(MAX_CHARS);
                job.term  = 1'b1;
            end else begin
                n_phase = PH_ONE;
                n_first = i_byte;
            end
        end
        if (!i_empty) begin
            job.chars[0] = sym_of(a[7:2]);
            job.chars[1] = sym_of({a[1:0], b[7:4]});
            job.chars[2] = (nbytes > 2'd1) ? sym_of({b[3:0], c[7:6]}) : CH_PAD;
            job.chars[3] = (nbytes > 2'd2) ? sym_of(c[5:0]) : CH_PAD;
            job.chars[4] = CH_TERM;
        end
    end

    assign o_advance = i_valid && ((job.count == '0) || i_buf_free);
    assign o_job     = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_EMPTY;
            r_first  <= 8'd0;
            r_second <= 8'd0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

### design/b64sp_char_buf.sv
// ----------------------------------------------------------------------------
// b64sp_char_buf
// Result buffer: holds the characters of one group and shifts them out one
// per output request.
// ----------------------------------------------------------------------------
module b64sp_char_buf
    import b64sp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_job              i_job,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic [MAX_CHARS-1:0][CHAR_W-1:0] r_chars;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_term;
    logic                             take;

    assign o_valid = (r_cnt != '0);
    assign take    = o_valid && i_ready;
    assign o_free  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);
    assign o_char  = r_chars[0];
    assign o_last  = r_term && (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_job.count;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_job.chars;
            r_term  <= i_job.term;
        end else if (take) begin
            r_chars <= {CH_PAD, r_chars[MAX_CHARS-1:1]};
        end
    end

endmodule

### design/base64_space_pad_encoder_unit.sv
// ----------------------------------------------------------------------------
// base64_space_pad_encoder_unit
// Base64 encoder, standard alphabet, space padding and '-' terminator.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata               | tlast     | tuser
//  s_axis   | in        | [7:0] data_byte     | last_byte | empty_message
//  m_axis   | out       | [6:0] out_char, [7] 0 | last_char | -
//
// A byte that only fills the group is taken without loading the character
// buffer; one that closes a group loads four or five characters (five when
// it ends the message), so the one-character result channel sets the
// sustained rate. A request passes the input register and the character
// buffer. Reset clears the group phase, held bytes and both valid flags.
// A stalled output holds the buffer and, once it is full, the input register.
// ----------------------------------------------------------------------------
module base64_space_pad_encoder_unit
    import b64sp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] empty_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              in_last;
    logic              in_empty;
    logic              advance;
    logic              buf_free;
    t_job              job;
    logic [CHAR_W-1:0] out_char;

    b64sp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_empty   (s_axis_tuser),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_last    (in_last),
        .o_empty   (in_empty)
    );

    b64sp_group u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .i_last     (in_last),
        .i_empty    (in_empty),
        .i_buf_free (buf_free),
        .o_advance  (advance),
        .o_job      (job)
    );

    b64sp_char_buf u_char_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && (job.count != '0)),
        .i_job   (job),
        .o_free  (buf_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (out_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

### verif/b64sp_checker.sv
// ----------------------------------------------------------------------------
// b64sp_checker
// Watches both stream channels of the space-padded base64 encoder, predicts
// the text each accepted request should produce and compares every accepted
// character and its terminator flag against the oldest prediction.
// ----------------------------------------------------------------------------
module b64sp_checker
    import b64sp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    input  logic       i_s_axis_tuser,   // [0] empty_message
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [6:0] out_char, [7] zero
    input  logic       i_m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              term;
    } t_text_char;

    t_text_char        expected_text[$];
    t_phase            group_phase;
    logic [7:0]        held_first;
    logic [7:0]        held_second;
    int                mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_text.size();

    function automatic logic [CHAR_W-1:0] base64_symbol(input logic [5:0] v);
        logic [7:0] c;
        c = ALPHABET[8*(63 - v) +: 8];
        return c[CHAR_W-1:0];
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] code, input logic term);
        t_text_char t;
        t.code = code;
        t.term = term;
        expected_text.push_back(t);
    endtask

    task automatic push_group(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input int count);
        push_char(base64_symbol(a[7:2]), 1'b0);
        push_char(base64_symbol({a[1:0], b[7:4]}), 1'b0);
        push_char(count > 1 ? base64_symbol({b[3:0], c[7:6]}) : CH_PAD, 1'b0);
        push_char(count > 2 ? base64_symbol(c[5:0]) : CH_PAD, 1'b0);
    endtask

    task automatic clear_group();
        group_phase = PH_EMPTY;
        held_first  = 8'h00;
        held_second = 8'h00;
    endtask

    task automatic encode_request(input logic [7:0] b, input logic lst, input logic emp);
        if (emp) begin
            clear_group();
            push_char(CH_TERM, 1'b1);
        end else begin
            case (group_phase)
                PH_ONE: begin
                    if (lst) begin
                        push_group(held_first, b, 8'h00, 2);
                        push_char(CH_TERM, 1'b1);
                        clear_group();
                    end else begin
                        held_second = b;
                        group_phase = PH_TWO;
                    end
                end
                PH_TWO: begin
                    push_group(held_first, held_second, b, 3);
                    clear_group();
                    if (lst) begin
                        push_char(CH_TERM, 1'b1);
                    end
                end
                default: begin
                    if (lst) begin
                        push_group(b, 8'h00, 8'h00, 1);
                        push_char(CH_TERM, 1'b1);
                        clear_group();
                    end else begin
                        held_first  = b;
                        held_second = 8'h00;
                        group_phase = PH_ONE;
                    end
                end
            endcase
        end
    endtask

    initial begin
        mismatches = 0;
        clear_group();
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            clear_group();
            expected_text.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                encode_request(i_s_axis_tdata, i_s_axis_tlast, i_s_axis_tuser);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected char %h last %b", $realtime,
                                 i_m_axis_tdata, i_m_axis_tlast);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (i_m_axis_tdata != {1'b0, want.code} || i_m_axis_tlast != want.term) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected char %h last %b, got char %h last %b",
                                     $realtime, {1'b0, want.code}, want.term,
                                     i_m_axis_tdata, i_m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random byte messages into the space-padded base64
// encoder with bursty input and a stalling output, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_TARGET = 280;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         items_sent = 0;
    t_rx_mode   rx_mode = RX_FREE;
    int         rx_left = 0;

    base64_space_pad_encoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    b64sp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[base64_space_pad_encoder_unit] ERROR");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (rx_left % 24 == 0);
        endcase
    end

    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hff;
        end
        return 8'($urandom);
    endfunction

    // hold each request until accepted; insert a gap between bursts
    task automatic send_request(input logic [7:0] b, input logic lst, input logic emp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        s_axis_tuser  <= emp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    initial begin
        int roll;
        int len;
        int cut;
        int k;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, last flag ignored
        send_request(8'ha5, 1'b1, 1'b1);
        // single-byte messages: two symbols and two spaces
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        // two-byte message: three symbols and one space
        send_request(8'h4d, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        // full group closing the message
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        // plus symbols, then a zero group
        send_request(8'hfb, 1'b0, 1'b0);
        send_request(8'hef, 1'b0, 1'b0);
        send_request(8'hbe, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        // drop held bytes on an empty message mid-group
        send_request(8'h12, 1'b0, 1'b0);
        send_request(8'h34, 1'b1, 1'b1);
        send_request(8'h56, 1'b0, 1'b0);
        send_request(8'h78, 1'b0, 1'b0);
        send_request(8'h9a, 1'b0, 1'b1);
        // full group followed by a one-byte tail
        send_request(8'h80, 1'b0, 1'b0);
        send_request(8'h01, 1'b0, 1'b0);
        send_request(8'h7f, 1'b0, 1'b0);
        send_request(8'h55, 1'b1, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                send_request(random_byte(), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 9);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
                k = 0;
                while (k < len) begin
                    if (k == cut) begin
                        send_request(random_byte(), 1'($urandom_range(0, 1)), 1'b1);
                        k = len;
                    end else begin
                        send_request(random_byte(), k == len - 1, 1'b0);
                        k++;
                    end
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("[base64_space_pad_encoder_unit] OK");
        end else begin
            $display("[base64_space_pad_encoder_unit] ERROR");
        end
        $finish;
    end

endmodule
